// File: src/dgc_pkg.sv
// dgc_pkg: shared types and codes for the drawn graph edge crossing check.
// No dependencies.
`default_nettype none
package dgc_pkg;

    localparam int COORD_W = 24;
    localparam int ID_W    = 16;

    localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
    localparam logic [1:0] OP_LOAD_EDGE   = 2'd1;
    localparam logic [1:0] OP_CHECK       = 2'd2;
    localparam logic [1:0] OP_CLEAR       = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [ID_W-1:0]           vertex_id;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic [ID_W-1:0]           edge_from;
        logic [ID_W-1:0]           edge_to;
    } cmd_t;

    typedef struct packed {
        logic       no_crossing;
        logic [1:0] status;
    } res_t;

    // endpoint lookup query travelling down the vertex cells
    typedef struct packed {
        logic                      valid;
        logic [ID_W-1:0]           from_id;
        logic [ID_W-1:0]           to_id;
        logic                      from_found;
        logic                      to_found;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
    } vq_t;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } pt_stat_t;

endpackage
`default_nettype wire

// File: src/drawn_graph_edge_crossing_check.sv
// drawn_graph_edge_crossing_check: top level, tables, control and cell chain.
// Depends on dgc_pkg, dgc_ram, dgc_vertex_cell, dgc_pair_test.
`default_nettype none
// Load vertex, load edge and clear items leave busy low and may come
// back to back. A check item holds busy until its result strobes on
// result_valid for one cycle; the receiver cannot stall it. The check first
// streams every edge through a chain of MAX_VERTICES vertex cells to resolve
// endpoint ids, then, when the edge bound allows, walks all edge pairs
// through a pipelined intersection tester at one pair per cycle.
// Tables need no clearing after reset.
module drawn_graph_edge_crossing_check #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 128
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dgc_pkg::cmd_t cmd,
    output logic               result_valid,
    output dgc_pkg::res_t      result
);
    import dgc_pkg::*;

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int RW  = 2 * VIW + 4 * COORD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RES   = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_PAIR  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [VCW-1:0] vcount_reg, vcount_next;
    logic [ECW-1:0] ecount_reg, ecount_next;
    logic           ovf_reg, ovf_next;
    logic [ECW-1:0] ri_reg, ri_next;
    logic [ECW-1:0] wi_reg, wi_next;
    logic           issue_v_reg, issue_v_next;
    logic           unk_reg, unk_next;
    logic [EIW-1:0] pi_reg, pi_next;
    logic [EIW-1:0] pj_reg, pj_next;
    logic           pv0_reg, pv0_next;
    logic           cross_reg, cross_next;
    logic           rv_reg, rv_next;
    res_t           res_reg, res_next;

    logic           accept;
    logic           edge_we;
    logic [31:0]    edge_rdata;
    logic           res_we;
    logic [RW-1:0]  res_wdata, ra_rdata, rb_rdata;
    pt_stat_t       pt;

    vq_t            q     [MAX_VERTICES + 1];
    logic [VIW-1:0] fidx  [MAX_VERTICES + 1];
    logic [VIW-1:0] tidx  [MAX_VERTICES + 1];
    vq_t            q_end;

    assign accept  = start && !busy;
    assign busy    = state_reg != S_IDLE;
    assign edge_we = accept && cmd.opcode == OP_LOAD_EDGE && ecount_reg < ECW'(MAX_EDGES);

    dgc_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (ecount_reg[EIW-1:0]),
        .wdata ({cmd.edge_from, cmd.edge_to}),
        .raddr (ri_reg[EIW-1:0]),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        q[0]            = '0;
        q[0].valid      = issue_v_reg;
        q[0].from_id    = edge_rdata[31:16];
        q[0].to_id      = edge_rdata[15:0];
        fidx[0]         = '0;
        tidx[0]         = '0;
    end

    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        dgc_vertex_cell #(.IDX(k), .VCW(VCW), .VIW(VIW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load_en  (accept && cmd.opcode == OP_LOAD_VERTEX && vcount_reg == VCW'(k)),
            .load_cmd (cmd),
            .count    (vcount_reg),
            .q_in     (q[k]),
            .fidx_in  (fidx[k]),
            .tidx_in  (tidx[k]),
            .q_out    (q[k+1]),
            .fidx_out (fidx[k+1]),
            .tidx_out (tidx[k+1])
        );
    end

    assign q_end     = q[MAX_VERTICES];
    assign res_we    = q_end.valid;
    assign res_wdata = {fidx[MAX_VERTICES], tidx[MAX_VERTICES],
                        q_end.fx, q_end.fy, q_end.tx, q_end.ty};

    dgc_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_res_ram_a (
        .clk   (clk),
        .we    (res_we),
        .waddr (wi_reg[EIW-1:0]),
        .wdata (res_wdata),
        .raddr (pi_reg),
        .rdata (ra_rdata)
    );

    dgc_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_res_ram_b (
        .clk   (clk),
        .we    (res_we),
        .waddr (wi_reg[EIW-1:0]),
        .wdata (res_wdata),
        .raddr (pj_reg),
        .rdata (rb_rdata)
    );

    dgc_pair_test #(.VIW(VIW)) u_pair_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pv0_reg),
        .ea       (ra_rdata),
        .eb       (rb_rdata),
        .stat     (pt)
    );

    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        ecount_next  = ecount_reg;
        ovf_next     = ovf_reg;
        ri_next      = ri_reg;
        wi_next      = wi_reg;
        issue_v_next = 1'b0;
        unk_next     = unk_reg;
        pi_next      = pi_reg;
        pj_next      = pj_reg;
        pv0_next     = 1'b0;
        cross_next   = cross_reg;
        rv_next      = 1'b0;
        res_next     = res_reg;

        if (res_we)
        begin
            wi_next = wi_reg + 1'b1;
            if (!q_end.from_found || !q_end.to_found)
            begin
                unk_next = 1'b1;
            end
        end
        if (pt.hit_valid && pt.hit)
        begin
            cross_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        OP_LOAD_VERTEX:
                        begin
                            if (vcount_reg < VCW'(MAX_VERTICES))
                            begin
                                vcount_next = vcount_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_EDGE:
                        begin
                            if (edge_we)
                            begin
                                ecount_next = ecount_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_CHECK:
                        begin
                            state_next = S_RES;
                            ri_next    = '0;
                            wi_next    = '0;
                            unk_next   = 1'b0;
                        end
                        default:
                        begin
                            vcount_next = '0;
                            ecount_next = '0;
                            ovf_next    = 1'b0;
                        end
                    endcase
                end
            end
            S_RES:
            begin
                if (ri_reg < ecount_reg)
                begin
                    ri_next      = ri_reg + 1'b1;
                    issue_v_next = 1'b1;
                end
                if (wi_reg == ecount_reg)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next.status = ovf_reg ? ST_OVERFLOW : (unk_reg ? ST_UNKNOWN : ST_OK);
                state_next      = S_IDLE;
                rv_next         = 1'b1;
                if (unk_reg)
                begin
                    res_next.no_crossing = 1'b0;
                end
                else if (vcount_reg < VCW'(3))
                begin
                    res_next.no_crossing = 1'b1;
                end
                else if (32'(ecount_reg) + 32'd6 > 32'(vcount_reg) * 32'd3)
                begin
                    res_next.no_crossing = 1'b0;
                end
                else if (ecount_reg < ECW'(2))
                begin
                    res_next.no_crossing = 1'b1;
                end
                else
                begin
                    state_next = S_PAIR;
                    rv_next    = 1'b0;
                    pi_next    = '0;
                    pj_next    = EIW'(1);
                    cross_next = 1'b0;
                end
            end
            S_PAIR:
            begin
                pv0_next = 1'b1;
                if (ECW'(pj_reg) == ecount_reg - 1'b1)
                begin
                    if (ECW'(pi_reg) == ecount_reg - ECW'(2))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        pi_next = pi_reg + 1'b1;
                        pj_next = pi_reg + EIW'(2);
                    end
                end
                else
                begin
                    pj_next = pj_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!pv0_reg && !pt.busy)
                begin
                    res_next.no_crossing = !cross_reg;
                    state_next           = S_IDLE;
                    rv_next              = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= '0;
            ecount_reg  <= '0;
            ovf_reg     <= 1'b0;
            issue_v_reg <= 1'b0;
            pv0_reg     <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            ecount_reg  <= ecount_next;
            ovf_reg     <= ovf_next;
            issue_v_reg <= issue_v_next;
            pv0_reg     <= pv0_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ri_reg    <= ri_next;
        wi_reg    <= wi_next;
        unk_reg   <= unk_next;
        pi_reg    <= pi_next;
        pj_reg    <= pj_next;
        cross_reg <= cross_next;
        res_reg   <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;
endmodule
`default_nettype wire

// File: src/dgc_ram.sv
// dgc_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none
module dgc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: src/dgc_vertex_cell.sv
// dgc_vertex_cell: holds one vertex and resolves endpoint ids of a passing query.
// Depends on dgc_pkg.
`default_nettype none
module dgc_vertex_cell #(
    parameter int IDX = 0,
    parameter int VCW = 7,
    parameter int VIW = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load_en,
    input  wire dgc_pkg::cmd_t         load_cmd,
    input  wire logic [VCW-1:0]        count,
    input  wire dgc_pkg::vq_t          q_in,
    input  wire logic [VIW-1:0]        fidx_in,
    input  wire logic [VIW-1:0]        tidx_in,
    output dgc_pkg::vq_t               q_out,
    output logic [VIW-1:0]             fidx_out,
    output logic [VIW-1:0]             tidx_out
);
    import dgc_pkg::*;

    logic [ID_W-1:0]           id_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic                      valid_reg;
    vq_t                       q_reg;
    vq_t                       q_next;
    logic [VIW-1:0]            fidx_reg, fidx_next;
    logic [VIW-1:0]            tidx_reg, tidx_next;
    logic                      live;

    assign live = VCW'(IDX) < count;

    always_comb
    begin
        q_next    = q_in;
        fidx_next = fidx_in;
        tidx_next = tidx_in;
        if (live && !q_in.from_found && q_in.from_id == id_reg)
        begin
            q_next.from_found = 1'b1;
            q_next.fx         = x_reg;
            q_next.fy         = y_reg;
            fidx_next         = VIW'(IDX);
        end
        if (live && !q_in.to_found && q_in.to_id == id_reg)
        begin
            q_next.to_found = 1'b1;
            q_next.tx       = x_reg;
            q_next.ty       = y_reg;
            tidx_next       = VIW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= q_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            id_reg <= load_cmd.vertex_id;
            x_reg  <= load_cmd.x_coord;
            y_reg  <= load_cmd.y_coord;
        end
        q_reg    <= q_next;
        fidx_reg <= fidx_next;
        tidx_reg <= tidx_next;
    end

    always_comb
    begin
        q_out       = q_reg;
        q_out.valid = valid_reg;
    end
    assign fidx_out = fidx_reg;
    assign tidx_out = tidx_reg;
endmodule
`default_nettype wire

// File: src/dgc_pair_test.sv
// dgc_pair_test: three-stage segment intersection test for one edge pair.
// Depends on dgc_pkg.
`default_nettype none
module dgc_pair_test #(
    parameter int VIW = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [2*VIW+4*dgc_pkg::COORD_W-1:0] ea,
    input  wire logic [2*VIW+4*dgc_pkg::COORD_W-1:0] eb,
    output dgc_pkg::pt_stat_t                 stat
);
    import dgc_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;
    localparam logic [1:0] OR_COL = 2'd0;
    localparam logic [1:0] OR_CCW = 2'd1;
    localparam logic [1:0] OR_CW  = 2'd2;

    function automatic logic signed [DW-1:0] dif(input logic signed [COORD_W-1:0] p,
                                                 input logic signed [COORD_W-1:0] q);
        dif = DW'(p) - DW'(q);
    endfunction

    // whether (xb,yb) lies in the box spanned by (xa,ya) and (xc,yc)
    function automatic logic box(input logic signed [COORD_W-1:0] xa,
                                 input logic signed [COORD_W-1:0] ya,
                                 input logic signed [COORD_W-1:0] xb,
                                 input logic signed [COORD_W-1:0] yb,
                                 input logic signed [COORD_W-1:0] xc,
                                 input logic signed [COORD_W-1:0] yc);
        logic okx, oky;
        okx = (xa > xc) ? (xb <= xa && xb >= xc) : (xb <= xc && xb >= xa);
        oky = (ya > yc) ? (yb <= ya && yb >= yc) : (yb <= yc && yb >= ya);
        box = okx && oky;
    endfunction

    function automatic logic [1:0] orient(input logic signed [PW-1:0] p,
                                          input logic signed [PW-1:0] q);
        if (p == q)
        begin
            orient = OR_COL;
        end
        else if (p > q)
        begin
            orient = OR_CCW;
        end
        else
        begin
            orient = OR_CW;
        end
    endfunction

    logic [VIW-1:0]            ia, ib, ic, idd;
    logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc, xd, yd;

    assign {ia, ib, xa, ya, xb, yb} = ea;
    assign {ic, idd, xc, yc, xd, yd} = eb;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  skip1_reg, skip2_reg;
    logic [3:0]            box1_reg, box2_reg;
    logic signed [DW-1:0]  d_reg [12];
    logic signed [PW-1:0]  p_reg [8];
    logic                  hit_reg;
    logic [1:0]            o1, o2, o3, o4;
    logic                  meet;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        o1 = orient(p_reg[0], p_reg[1]);
        o2 = orient(p_reg[2], p_reg[3]);
        o3 = orient(p_reg[4], p_reg[5]);
        o4 = orient(p_reg[6], p_reg[7]);
        meet = (o1 != o2 && o3 != o4)
            || (o1 == OR_COL && box2_reg[0]) || (o2 == OR_COL && box2_reg[1])
            || (o3 == OR_COL && box2_reg[2]) || (o4 == OR_COL && box2_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        skip1_reg <= ia == ic || ia == idd || ib == ic || ib == idd;
        box1_reg  <= {box(xc, yc, xb, yb, xd, yd), box(xc, yc, xa, ya, xd, yd),
                      box(xa, ya, xd, yd, xb, yb), box(xa, ya, xc, yc, xb, yb)};
        d_reg[0]  <= dif(xb, xa);
        d_reg[1]  <= dif(yb, ya);
        d_reg[2]  <= dif(xc, xa);
        d_reg[3]  <= dif(yc, ya);
        d_reg[4]  <= dif(xd, xa);
        d_reg[5]  <= dif(yd, ya);
        d_reg[6]  <= dif(xd, xc);
        d_reg[7]  <= dif(yd, yc);
        d_reg[8]  <= dif(xa, xc);
        d_reg[9]  <= dif(ya, yc);
        d_reg[10] <= dif(xb, xc);
        d_reg[11] <= dif(yb, yc);

        skip2_reg <= skip1_reg;
        box2_reg  <= box1_reg;
        p_reg[0]  <= PW'(d_reg[0]) * PW'(d_reg[3]);
        p_reg[1]  <= PW'(d_reg[1]) * PW'(d_reg[2]);
        p_reg[2]  <= PW'(d_reg[0]) * PW'(d_reg[5]);
        p_reg[3]  <= PW'(d_reg[1]) * PW'(d_reg[4]);
        p_reg[4]  <= PW'(d_reg[6]) * PW'(d_reg[9]);
        p_reg[5]  <= PW'(d_reg[7]) * PW'(d_reg[8]);
        p_reg[6]  <= PW'(d_reg[6]) * PW'(d_reg[11]);
        p_reg[7]  <= PW'(d_reg[7]) * PW'(d_reg[10]);

        hit_reg   <= !skip2_reg && meet;
    end

    assign stat.busy      = v1_reg || v2_reg || v3_reg;
    assign stat.hit_valid = v3_reg;
    assign stat.hit       = hit_reg;
endmodule
`default_nettype wire
